// File: hdl/newton_square_root_defines.svh
// ----------------------------------------------------------------------------
// newton square root assertion macros
// shared property wrappers on clk with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// same-cycle implication
`define NSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// widths, limits and status codes of the newton square root block
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = DATA_WIDTH - 1;
    localparam int SQ_WIDTH   = 2 * ROOT_WIDTH;
    localparam int SC_WIDTH   = ROOT_WIDTH + FRAC_BITS;
    localparam int NUM_WIDTH  = ((SQ_WIDTH > SC_WIDTH) ? SQ_WIDTH : SC_WIDTH) + 1;
    localparam int CNT_WIDTH  = $clog2(NUM_WIDTH);

    localparam int TOL_WIDTH   = 16;
    localparam int ITER_WIDTH  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 2;
    localparam int ROUND_CAP   = 64;

    localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 16'd66;
    localparam logic [ITER_WIDTH-1:0] ITER_RESET = 7'd32;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd2;

    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = {ROOT_WIDTH{1'b1}};

endpackage

// File: hdl/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// fixed-point newton-raphson square root with a serial restoring divider
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A non-positive value
// answers in the next cycle with the invalid status. Otherwise each Newton
// round runs the squaring multiplier, then the numerator add, then the shared
// restoring divider at one quotient bit per cycle, then an update step. A
// request runs at most 64 rounds, the round cap. The result is shown for
// exactly one cycle with done high and must be captured then; busy is already
// low in that cycle, so a new request may be given at once.
// ----------------------------------------------------------------------------
`include "newton_square_root_defines.svh"

module newton_square_root
    import nsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                   done,
    output logic [ROOT_WIDTH-1:0]  root,
    output logic [ITER_WIDTH-1:0]  rounds_used,
    output logic [STATUS_W-1:0]    status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TOL_WIDTH-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [TOL_WIDTH-1:0]  tol_reg;
    logic [ITER_WIDTH-1:0] iter_reg;
    logic [ITER_WIDTH-1:0] limit_reg, limit_next;
    logic [ITER_WIDTH-1:0] rounds_reg, rounds_next;
    logic [ROOT_WIDTH-1:0] g_reg, g_next;
    logic [SC_WIDTH-1:0]   scaled_reg, scaled_next;
    logic [SQ_WIDTH-1:0]   sq_reg, sq_next;
    logic [NUM_WIDTH-1:0]  num_reg, num_next;
    logic [DATA_WIDTH:0]   rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0] q_reg, q_next;
    logic                  sat_reg, sat_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [ROOT_WIDTH-1:0] root_reg, root_next;
    logic [ITER_WIDTH-1:0] rused_reg, rused_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  accept;
    logic                  invalid;
    logic [ROOT_WIDTH-1:0] v_pos;
    logic [ROOT_WIDTH-1:0] half;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   divisor;
    logic                  qbit;
    logic [ROOT_WIDTH-1:0] ng;
    logic [ROOT_WIDTH-1:0] ng_fix;
    logic [ROOT_WIDTH-1:0] diff;
    logic [ITER_WIDTH-1:0] rounds_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign invalid   = value[DATA_WIDTH-1] || (value == '0);
    assign v_pos     = value[ROOT_WIDTH-1:0];
    assign half      = v_pos >> 1;
    assign rem_sh    = {rem_reg[DATA_WIDTH-1:0], num_reg[NUM_WIDTH-1]};
    assign divisor   = {1'b0, g_reg, 1'b0};
    assign qbit      = (rem_sh >= divisor);
    assign ng        = sat_reg ? ROOT_MAX : q_reg;
    assign ng_fix    = (ng == '0) ? ROOT_WIDTH'(1) : ng;
    assign diff      = (ng >= g_reg) ? (ng - g_reg) : (g_reg - ng);
    assign rounds_inc = rounds_reg + ITER_WIDTH'(1);

    always_comb
    begin
        state_next  = state_reg;
        limit_next  = limit_reg;
        rounds_next = rounds_reg;
        g_next      = g_reg;
        scaled_next = scaled_reg;
        sq_next     = sq_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        root_next   = root_reg;
        rused_next  = rused_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (invalid)
                    begin
                        done_next   = 1'b1;
                        root_next   = '0;
                        rused_next  = '0;
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        if (iter_reg == '0)
                            limit_next = ITER_WIDTH'(1);
                        else if (iter_reg > ITER_WIDTH'(ROUND_CAP))
                            limit_next = ITER_WIDTH'(ROUND_CAP);
                        else
                            limit_next = iter_reg;
                        g_next      = (half == '0) ? ROOT_WIDTH'(1) : half;
                        scaled_next = {v_pos, {FRAC_BITS{1'b0}}};
                        rounds_next = '0;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                sq_next    = g_reg * g_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                num_next   = NUM_WIDTH'(sq_reg) + NUM_WIDTH'(scaled_reg);
                rem_next   = '0;
                q_next     = '0;
                sat_next   = 1'b0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = qbit ? (rem_sh - divisor) : rem_sh;
                num_next = {num_reg[NUM_WIDTH-2:0], 1'b0};
                q_next   = {q_reg[ROOT_WIDTH-2:0], qbit};
                sat_next = sat_reg | q_reg[ROOT_WIDTH-1];
                cnt_next = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(NUM_WIDTH - 1))
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                rounds_next = rounds_inc;
                g_next      = ng_fix;
                if (diff < ROOT_WIDTH'(tol_reg))
                begin
                    done_next   = 1'b1;
                    root_next   = ng_fix;
                    rused_next  = rounds_inc;
                    status_next = ST_CONVERGED;
                    state_next  = S_IDLE;
                end
                else if (rounds_inc >= limit_reg)
                begin
                    done_next   = 1'b1;
                    root_next   = ng_fix;
                    rused_next  = rounds_inc;
                    status_next = ST_LIMIT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            tol_reg   <= TOL_RESET;
            iter_reg  <= ITER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOLERANCE: tol_reg  <= cfg_data;
                    REG_MAX_ITER:  iter_reg <= cfg_data[ITER_WIDTH-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg  <= limit_next;
        rounds_reg <= rounds_next;
        g_reg      <= g_next;
        scaled_reg <= scaled_next;
        sq_reg     <= sq_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
        cnt_reg    <= cnt_next;
        root_reg   <= root_next;
        rused_reg  <= rused_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign root        = root_reg;
    assign rounds_used = rused_reg;
    assign status      = status_reg;

    `NSR_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
    `NSR_ASSERT_NOW(a_invalid_zero, done && (status == ST_INVALID),
        (root == '0) && (rounds_used == '0), "invalid result not cleared")
    `NSR_ASSERT_NOW(a_valid_rounds, done && (status != ST_INVALID),
        (rounds_used != '0) && (rounds_used <= ITER_WIDTH'(ROUND_CAP)) && (root != '0),
        "bad round count or zero root")
    `NSR_ASSERT_NEXT(a_start_busy, accept && !invalid, busy && !done,
        "positive request did not start")

endmodule
